// ----- rtl/core/smt_pkg.sv -----
// Shared types, constants and helper functions for the strand tagger.
// No dependencies.
package smt_pkg;

    localparam int GENOME_BASES = 4194304;
    localparam int MAX_SEGMENTS = 1024;
    localparam int STORE_WORDS  = (GENOME_BASES + 15) / 16;
    localparam int ADDR_W       = $clog2(STORE_WORDS);
    localparam int BL_W         = $clog2(GENOME_BASES + 1);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int QDEPTH       = 2;

    // Item kinds after classification
    localparam logic [2:0] K_LOAD   = 3'd0;
    localparam logic [2:0] K_BEGIN  = 3'd1;
    localparam logic [2:0] K_DIGIT  = 3'd2;
    localparam logic [2:0] K_CLEAR  = 3'd3;
    localparam logic [2:0] K_INTRON = 3'd4;
    localparam logic [2:0] K_EXTEND = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;

    // Input actions
    localparam logic [1:0] A_LOAD  = 2'd0;
    localparam logic [1:0] A_BEGIN = 2'd1;
    localparam logic [1:0] A_CIGAR = 2'd2;
    localparam logic [1:0] A_END   = 2'd3;

    // Strand codes
    localparam logic [1:0] S_NONE  = 2'd0;
    localparam logic [1:0] S_PLUS  = 2'd1;
    localparam logic [1:0] S_MINUS = 2'd2;
    localparam logic [1:0] S_UNK   = 2'd3;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  val;
        logic [22:0] read_start;
        logic [21:0] chrom_offset;
        logic [22:0] chrom_length;
        logic        prior_tag;
    } t_item;

    typedef struct packed {
        logic       push_ok;
        logic [1:0] count;
    } t_q_stat;

    function automatic logic [1:0] motif_strand(input logic [7:0] code);
        case (code)
            8'hb2, 8'h92, 8'h31: motif_strand = S_PLUS;
            8'h71, 8'h79, 8'hb3: motif_strand = S_MINUS;
            default:             motif_strand = S_UNK;
        endcase
    endfunction

endpackage

// ----- rtl/core/splice_motif_strand_tagger_unit.sv -----
// Top level of the splice-junction strand tagger.
// Depends on smt_pkg, smt_front, smt_queue and smt_back.

// Letters, begin, digit, operator and end items are handled in the back-end
// idle state; an intron operator (N) also steps through issue and finish, as
// its four dinucleotide bases are read one per cycle from the base store.
// A two-entry queue sits between the classifying front end and the back
// end, and busy rises only when it is full. Every end-of-read item gives one
// strand tag on o_strand_tag, marked by o_strobe for one cycle; the receiver
// cannot stall, so the tag must be taken in that cycle.
module splice_motif_strand_tagger_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    input  logic [22:0] i_read_start,
    input  logic [21:0] i_chrom_offset,
    input  logic [22:0] i_chrom_length,
    input  logic        i_already_tagged,
    output logic        o_strobe,
    output logic [1:0]  o_strand_tag
);
    import smt_pkg::*;

    logic    w_push, w_pop, w_valid, w_end_exec, w_take;
    t_item   w_fitem, w_qitem;
    t_q_stat w_qstat;

    assign busy   = !w_qstat.push_ok;
    assign w_take = start && !busy;

    smt_front u_front (
        .i_take(w_take), .i_action(i_action), .i_symbol(i_symbol),
        .i_read_start(i_read_start), .i_chrom_offset(i_chrom_offset),
        .i_chrom_length(i_chrom_length), .i_already_tagged(i_already_tagged),
        .o_push(w_push), .o_item(w_fitem)
    );

    smt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(w_fitem),
        .i_pop(w_pop), .o_valid(w_valid), .o_item(w_qitem), .o_stat(w_qstat)
    );

    smt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_qitem),
        .o_pop(w_pop), .o_end_exec(w_end_exec), .o_strobe(o_strobe),
        .o_strand_tag(o_strand_tag)
    );

    a_strobe_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_end_exec))
        else $error("tag strobe without an end item");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_qstat.count != 2'd0))
        else $error("pushed item missing from queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid)
        else $error("pop from empty queue");

endmodule

// ----- rtl/core/smt_front.sv -----
// Front end: accepts items and classifies letters and CIGAR characters.
// Depends on smt_pkg.
module smt_front (
    input  logic               i_take,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_symbol,
    input  logic [22:0]        i_read_start,
    input  logic [21:0]        i_chrom_offset,
    input  logic [22:0]        i_chrom_length,
    input  logic               i_already_tagged,
    output logic               o_push,
    output smt_pkg::t_item     o_item
);
    import smt_pkg::*;

    logic [7:0] w_up;
    logic       w_keep;

    always_comb begin
        w_up   = (i_symbol >= 8'h61 && i_symbol <= 8'h7a) ? i_symbol - 8'h20 : i_symbol;
        w_keep = 1'b1;
        o_item = '0;
        o_item.read_start   = i_read_start;
        o_item.chrom_offset = i_chrom_offset;
        o_item.chrom_length = i_chrom_length;
        o_item.prior_tag    = i_already_tagged;
        case (i_action)
            A_LOAD: begin
                o_item.kind = K_LOAD;
                // drop anything that is not a letter
                w_keep = (w_up >= 8'h41 && w_up <= 8'h5a);
                case (w_up)
                    8'h41, 8'h4e: o_item.val = {2'b00, BASE_A};
                    8'h43:        o_item.val = {2'b00, BASE_C};
                    8'h47:        o_item.val = {2'b00, BASE_G};
                    default:      o_item.val = {2'b00, BASE_T};
                endcase
            end
            A_BEGIN: o_item.kind = K_BEGIN;
            A_CIGAR: begin
                if (i_symbol >= 8'h30 && i_symbol <= 8'h39) begin
                    o_item.kind = K_DIGIT;
                    o_item.val  = 4'(i_symbol - 8'h30);
                end else if (i_symbol == 8'h49 || i_symbol == 8'h53 ||
                             i_symbol == 8'h48 || i_symbol == 8'h50) begin
                    o_item.kind = K_CLEAR;
                end else if (i_symbol == 8'h4e) begin
                    o_item.kind = K_INTRON;
                end else begin
                    o_item.kind = K_EXTEND;
                end
            end
            default: o_item.kind = K_END;
        endcase
        o_push = i_take && w_keep;
    end

endmodule

// ----- rtl/core/smt_queue.sv -----
// Short register queue between front and back ends.
// Depends on smt_pkg.
module smt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smt_pkg::t_item     i_item,
    input  logic               i_pop,
    output logic               o_valid,
    output smt_pkg::t_item     o_item,
    output smt_pkg::t_q_stat   o_stat
);
    import smt_pkg::*;

    t_item      r_buf [0:QDEPTH-1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid       = (r_cnt != 2'd0);
    assign o_item        = r_buf[r_rp];
    assign o_stat.push_ok = (r_cnt != 2'(QDEPTH));
    assign o_stat.count  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- rtl/core/smt_back.sv -----
// Back end: base store, read state and the intron fetch sequencer.
// Depends on smt_pkg.
module smt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  smt_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_end_exec,
    output logic               o_strobe,
    output logic [1:0]         o_strand_tag
);
    import smt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISS  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [31:0]      r_mem [0:STORE_WORDS-1];
    logic [31:0]      r_mem_q;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [BL_W-1:0]  r_bl, n_bl;
    logic [31:0]      r_fill, n_fill;
    logic [31:0]      r_start, n_start;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_acc, n_acc;
    logic [SEG_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_pend, n_pend;
    logic [1:0]       r_dec, n_dec;
    logic [21:0]      r_off, n_off;
    logic [22:0]      r_clen, n_clen;
    logic             r_tag, n_tag;
    logic [31:0]      r_donor, n_donor;
    logic [31:0]      r_accept, n_accept;
    logic [5:0]       r_code, n_code;
    logic             r_col, n_col;
    logic             r_rd_ok, n_rd_ok;
    logic [3:0]       r_lane, n_lane;
    logic             r_strobe, n_strobe;
    logic [1:0]       r_out, n_out;

    logic             w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [31:0]      w_word;
    logic [31:0]      w_pos;
    logic [23:0]      w_idx;
    logic [1:0]       w_base;
    logic [7:0]       w_full;
    logic [SEG_W-1:0] w_cnt1;

    assign o_pop        = (r_state == ST_IDLE) && i_valid;
    assign o_end_exec   = o_pop && (i_item.kind == K_END);
    assign o_strobe     = r_strobe;
    assign o_strand_tag = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_word;
        r_mem_q <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state; n_step = r_step; n_bl = r_bl; n_fill = r_fill;
        n_start = r_start; n_len = r_len; n_acc = r_acc; n_cnt = r_cnt;
        n_pend = r_pend; n_dec = r_dec; n_off = r_off; n_clen = r_clen;
        n_tag = r_tag; n_donor = r_donor; n_accept = r_accept; n_code = r_code;
        n_col = 1'b0; n_rd_ok = 1'b0; n_lane = r_lane;
        n_strobe = 1'b0; n_out = r_out;
        w_we = 1'b0;
        w_waddr = r_bl[ADDR_W+3:4];
        w_word = ((r_bl[3:0] == 4'd0) ? 32'd0 : r_fill)
               | ({30'd0, i_item.val[1:0]} << {r_bl[3:0], 1'b0});
        w_cnt1 = r_cnt + SEG_W'(1);

        // base read address for the current step of the sequencer
        case (r_step)
            2'd0:    w_pos = r_donor - 32'd1;
            2'd1:    w_pos = r_donor;
            2'd2:    w_pos = r_accept - 32'd3;
            default: w_pos = r_accept - 32'd2;
        endcase
        w_idx   = {2'b00, r_off} + {1'b0, w_pos[22:0]};
        w_raddr = w_idx[ADDR_W+3:4];
        w_base  = r_rd_ok ? r_mem_q[{r_lane, 1'b0} +: 2] : BASE_T;
        w_full  = {r_code, w_base};
        if (r_col) n_code = w_full[5:0];

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_item.kind)
                        K_LOAD: begin
                            if (r_bl < BL_W'(GENOME_BASES)) begin
                                w_we   = 1'b1;
                                n_fill = w_word;
                                n_bl   = r_bl + BL_W'(1);
                            end
                        end
                        K_BEGIN: begin
                            n_start = {9'd0, i_item.read_start};
                            n_len = '0; n_acc = '0; n_cnt = '0;
                            n_pend = S_NONE; n_dec = S_NONE;
                            n_off = i_item.chrom_offset;
                            n_clen = i_item.chrom_length;
                            n_tag = i_item.prior_tag;
                        end
                        K_DIGIT: n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                                       + {28'd0, i_item.val};
                        K_CLEAR: n_acc = '0;
                        K_EXTEND: begin
                            n_len = r_len + r_acc;
                            n_acc = '0;
                        end
                        K_INTRON: begin
                            n_donor = r_start + r_len;
                            n_step  = 2'd0;
                            n_state = ST_ISS;
                        end
                        default: begin
                            // end of read: close the last segment, then answer
                            n_tag = r_tag | i_item.prior_tag;
                            if (r_len != 32'd0 && r_cnt < SEG_W'(MAX_SEGMENTS)) begin
                                if (r_dec == S_NONE && (r_pend == S_PLUS || r_pend == S_MINUS))
                                    n_dec = r_pend;
                                n_pend = S_NONE;
                                n_cnt  = w_cnt1;
                                n_len  = '0;
                            end
                            n_strobe = 1'b1;
                            if (n_cnt <= SEG_W'(1) || n_tag)
                                n_out = S_NONE;
                            else if (n_dec != S_NONE)
                                n_out = n_dec;
                            else
                                n_out = S_UNK;
                        end
                    endcase
                end
            end
            ST_ISS: begin
                if (r_step == 2'd0) n_accept = r_donor + r_acc;
                n_rd_ok = !w_pos[31] && (w_pos < {9'd0, r_clen})
                        && (w_idx < {{(24-BL_W){1'b0}}, r_bl});
                n_lane  = w_idx[3:0];
                n_col   = 1'b1;
                n_step  = r_step + 2'd1;
                if (r_step == 2'd3) n_state = ST_FIN;
            end
            default: begin
                // last base lands now; apply the junction
                if (r_cnt < SEG_W'(MAX_SEGMENTS)) begin
                    if (r_dec == S_NONE && (r_pend == S_PLUS || r_pend == S_MINUS))
                        n_dec = r_pend;
                    n_cnt  = w_cnt1;
                    n_pend = (w_cnt1 < SEG_W'(MAX_SEGMENTS)) ? motif_strand(w_full) : S_NONE;
                end else begin
                    n_pend = S_NONE;
                end
                n_start = r_accept;
                n_len   = '0;
                n_acc   = '0;
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fill <= n_fill; r_donor <= n_donor; r_accept <= n_accept;
        r_code <= n_code; r_rd_ok <= n_rd_ok; r_lane <= n_lane; r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_step <= 2'd0; r_bl <= '0;
            r_start <= '0; r_len <= '0; r_acc <= '0; r_cnt <= '0;
            r_pend <= S_NONE; r_dec <= S_NONE; r_off <= '0; r_clen <= '0;
            r_tag <= 1'b0; r_col <= 1'b0; r_strobe <= 1'b0;
        end else begin
            r_state <= n_state; r_step <= n_step; r_bl <= n_bl;
            r_start <= n_start; r_len <= n_len; r_acc <= n_acc; r_cnt <= n_cnt;
            r_pend <= n_pend; r_dec <= n_dec; r_off <= n_off; r_clen <= n_clen;
            r_tag <= n_tag; r_col <= n_col; r_strobe <= n_strobe;
        end
    end

endmodule
